FILE: rtl/text_console_scrollback_core_assert.svh
// ----------------------------------------------------------------------------
// text console assertion macros
// concurrent assertion wrappers shared by the console rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLLBACK_CORE_ASSERT_SVH
`define TEXT_CONSOLE_SCROLLBACK_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// shared types and codes of the text console
// ----------------------------------------------------------------------------
package tcs_pkg;

	localparam int FUNC_W     = 3;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_ADDR_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_PRINT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCROLL = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	localparam logic [3:0] FG_RESET = 4'hF;
	localparam logic [3:0] BG_RESET = 4'h0;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_SET,
		OP_SCROLL,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       char_code;
		logic [6:0]       col;
		logic [4:0]       row;
		logic [7:0]       delta;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic       was_cleared;
		logic [7:0] cell_color;
		logic [7:0] cell_char;
		logic [5:0] view_offset;
		logic [6:0] cursor_row;
		logic [6:0] cursor_col;
	} result_t;

endpackage

FILE: rtl/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module tcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 5120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/tcs_front.sv
// ----------------------------------------------------------------------------
// tcs_front
// accepts command transfers and classifies them into queue entries
// ----------------------------------------------------------------------------
module tcs_front import tcs_pkg::*; (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [FUNC_W-1:0]    s_tuser,
	input  q_status_t            q_stat,
	input  logic                 clr_busy,
	output logic                 push,
	output cmd_t                 push_cmd
);

	logic [7:0] char_code;

	assign char_code = s_tdata[7:0];
	assign s_tready  = !q_stat.full && !clr_busy;
	assign push      = s_tvalid && s_tready;

	always_comb begin
		push_cmd.char_code = char_code;
		push_cmd.col       = s_tdata[14:8];
		push_cmd.row       = s_tdata[19:15];
		push_cmd.delta     = s_tdata[27:20];
		unique case (s_tuser)
			FUNC_PRINT:  push_cmd.op = (char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
			FUNC_SET:    push_cmd.op = OP_SET;
			FUNC_SCROLL: push_cmd.op = OP_SCROLL;
			FUNC_CLEAR:  push_cmd.op = OP_CLEAR;
			FUNC_READ:   push_cmd.op = OP_READ;
			default:     push_cmd.op = OP_NOP;
		endcase
	end

endmodule

FILE: rtl/tcs_fifo.sv
// ----------------------------------------------------------------------------
// tcs_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module tcs_fifo import tcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t q_stat
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/tcs_back.sv
// ----------------------------------------------------------------------------
// tcs_back
// executes queued commands against the cursor, view and cell store
// ----------------------------------------------------------------------------
module tcs_back import tcs_pkg::*; #(
	parameter int LINE_WIDTH   = 80,
	parameter int BUFFER_ROWS  = 64,
	parameter int VISIBLE_ROWS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  q_status_t q_stat,
	input  logic [7:0] cfg_color,
	output logic      pop,
	output logic      clr_busy,
	output logic      m_tvalid,
	input  logic      m_tready,
	output result_t   res
);

	localparam int XW    = $clog2(LINE_WIDTH);
	localparam int YW    = $clog2(BUFFER_ROWS);
	localparam int DEPTH = LINE_WIDTH * BUFFER_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = YW + 6;
	localparam int CLW   = XW + 8;
	localparam int VW    = YW + 8;
	localparam int SCW   = YW + 10;
	localparam int RW    = (YW > 7) ? YW : 7;
	localparam int XO    = (XW > 7) ? XW : 7;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_RUN   = 3'b010,
		ST_READ  = 3'b100
	} state_t;

	state_t        st_q;
	logic [AW-1:0] clr_addr_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;
	logic [YW-1:0] view_q;
	logic          m_valid_q;
	logic          rd_ok_q;
	result_t       res_q;

	logic [XW:0]    x_inc;
	logic [YW:0]    y_inc;
	logic           x_wrap;
	logic           y_ovf;
	logic           view_adv;
	logic [SW-1:0]  y_sum;
	logic           y_big;
	logic           col_big;
	logic [SCW-1:0] scr_sum;
	logic           rd_ok;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;
	logic [XW-1:0]  nx_x;
	logic [YW-1:0]  nx_y;
	logic [YW-1:0]  nx_view;
	logic           wipe;
	logic           line;
	logic           wr_char;
	logic           is_read;
	logic           out_free;
	logic           clr_last;
	logic           set_valid;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [15:0]    ram_wdata;
	logic [15:0]    ram_rdata;
	logic [RW-1:0]  nx_diff;
	logic [RW-1:0]  nx_view_w;
	logic [XO-1:0]  nx_x_w;
	logic [RW-1:0]  cur_diff;
	logic [RW-1:0]  cur_view_w;
	logic [XO-1:0]  cur_x_w;
	result_t        res_now;
	result_t        res_rd;

	assign out_free  = !m_valid_q || m_tready;
	assign pop       = (st_q == ST_RUN) && !q_stat.empty && out_free;
	assign clr_busy  = (st_q == ST_CLEAR);
	assign clr_last  = (clr_addr_q == AW'(DEPTH - 1));
	assign set_valid = (pop && !is_read) || (st_q == ST_READ);
	assign m_tvalid  = m_valid_q;
	assign res       = res_q;

	assign x_inc    = {1'b0, cur_x_q} + 1'b1;
	assign y_inc    = {1'b0, cur_y_q} + 1'b1;
	assign x_wrap   = (x_inc == (XW + 1)'(LINE_WIDTH));
	assign y_ovf    = (y_inc == (YW + 1)'(BUFFER_ROWS));
	assign view_adv = (VW'(y_inc) >= VW'(view_q) + VW'(VISIBLE_ROWS))
		&& (view_q < YW'(BUFFER_ROWS - 1));
	assign y_sum    = SW'(cmd.row) + SW'(view_q);
	assign y_big    = (y_sum >= SW'(BUFFER_ROWS));
	assign col_big  = (CLW'(cmd.col) >= CLW'(LINE_WIDTH));
	assign scr_sum  = SCW'(view_q) + {{(SCW - 8){cmd.delta[7]}}, cmd.delta};
	assign rd_ok    = !col_big && !y_big;
	assign wr_addr  = AW'(cur_x_q) + AW'(cur_y_q) * AW'(LINE_WIDTH);
	assign rd_addr  = AW'(cmd.col) + AW'(y_sum[YW-1:0]) * AW'(LINE_WIDTH);

	always_comb begin
		nx_x    = cur_x_q;
		nx_y    = cur_y_q;
		nx_view = view_q;
		wipe    = 1'b0;
		line    = 1'b0;
		wr_char = 1'b0;
		is_read = 1'b0;
		unique case (cmd.op)
			OP_CHAR: begin
				wr_char = 1'b1;
				if (x_wrap) begin
					line = 1'b1;
				end else begin
					nx_x = x_inc[XW-1:0];
				end
			end
			OP_NEWLINE: begin
				line = 1'b1;
			end
			OP_SET: begin
				nx_x = col_big ? XW'(LINE_WIDTH - 1) : XW'(cmd.col);
				nx_y = y_big ? YW'(BUFFER_ROWS - 1) : y_sum[YW-1:0];
			end
			OP_SCROLL: begin
				priority if (scr_sum[SCW-1]) begin
					nx_view = '0;
				end else if (scr_sum >= SCW'(BUFFER_ROWS)) begin
					nx_view = YW'(BUFFER_ROWS - 1);
				end else begin
					nx_view = scr_sum[YW-1:0];
				end
			end
			OP_CLEAR: begin
				wipe = 1'b1;
			end
			OP_READ: begin
				is_read = 1'b1;
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
		if (line) begin
			if (y_ovf) begin
				wipe = 1'b1;
			end else begin
				nx_x = '0;
				nx_y = y_inc[YW-1:0];
				if (view_adv) begin
					nx_view = view_q + 1'b1;
				end
			end
		end
		if (wipe) begin
			nx_x    = '0;
			nx_y    = '0;
			nx_view = '0;
		end
	end

	// result fields, truncated to port widths
	assign nx_diff    = RW'(nx_y) - RW'(nx_view);
	assign nx_view_w  = RW'(nx_view);
	assign nx_x_w     = XO'(nx_x);
	assign cur_diff   = RW'(cur_y_q) - RW'(view_q);
	assign cur_view_w = RW'(view_q);
	assign cur_x_w    = XO'(cur_x_q);

	always_comb begin
		res_now.cursor_col  = nx_x_w[6:0];
		res_now.cursor_row  = nx_diff[6:0];
		res_now.view_offset = nx_view_w[5:0];
		res_now.cell_char   = '0;
		res_now.cell_color  = '0;
		res_now.was_cleared = wipe;
		res_rd.cursor_col   = cur_x_w[6:0];
		res_rd.cursor_row   = cur_diff[6:0];
		res_rd.view_offset  = cur_view_w[5:0];
		res_rd.cell_char    = rd_ok_q ? ram_rdata[7:0] : 8'h00;
		res_rd.cell_color   = rd_ok_q ? ram_rdata[15:8] : 8'h00;
		res_rd.was_cleared  = 1'b0;
	end

	assign ram_we    = clr_busy || (pop && wr_char);
	assign ram_waddr = clr_busy ? clr_addr_q : wr_addr;
	assign ram_wdata = clr_busy ? 16'h0000 : {cfg_color, cmd.char_code};

	tcs_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop && is_read),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_addr_q <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			view_q     <= '0;
			m_valid_q  <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else begin
			if (set_valid) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					if (clr_last) begin
						clr_addr_q <= '0;
						st_q       <= ST_RUN;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_RUN: begin
					if (pop) begin
						cur_x_q <= nx_x;
						cur_y_q <= nx_y;
						view_q  <= nx_view;
						if (is_read) begin
							rd_ok_q <= rd_ok;
							st_q    <= ST_READ;
						end else if (wipe) begin
							st_q <= ST_CLEAR;
						end
					end
				end
				ST_READ: begin
					st_q <= ST_RUN;
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !is_read) begin
			res_q <= res_now;
		end else if (st_q == ST_READ) begin
			res_q <= res_rd;
		end
	end

endmodule

FILE: rtl/text_console_scrollback_core.sv
// ----------------------------------------------------------------------------
// text_console_scrollback_core
// text console with scrollback cell store, command stream in, status out
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_*       in   s_tvalid/s_tready          func, char_code, col, row, scroll_amount
// m_*       out  m_tvalid/m_tready          cursor, view, read cell, cleared flag
// apb       in   psel/penable/pwrite/pready fg_color, bg_color
//
// print, set cursor, scroll and unknown commands are executed as they are popped
// read also passes through ST_READ: one cell ram read port with registered data
// after reset and after every clear the back end zeroes the store, one cell a
// cycle over all LINE_WIDTH*BUFFER_ROWS cells (5120 by default), no input accepted then
// a two-entry queue and the output register let input and output stall apart
// ----------------------------------------------------------------------------
`include "text_console_scrollback_core_assert.svh"

module text_console_scrollback_core import tcs_pkg::*; #(
	parameter int LINE_WIDTH   = 80,
	parameter int BUFFER_ROWS  = 64,
	parameter int VISIBLE_ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // char_code, col, row, scroll_amount, zero pad
	input  logic [FUNC_W-1:0]     s_tuser,  // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // cursor_col, cursor_row, view_offset,
	                                        // cell_char, cell_color, was_cleared, zero pad
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [3:0] fg_q;
	logic [3:0] bg_q;
	logic       push;
	cmd_t       push_cmd;
	cmd_t       head;
	q_status_t  q_stat;
	logic       pop;
	logic       clr_busy;
	result_t    res;

	assign pready  = 1'b1;
	assign prdata  = {28'h0, (paddr[2] == REG_BG) ? bg_q : fg_q};
	assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FG:  fg_q <= pwdata[3:0];
				REG_BG:  bg_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	tcs_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.clr_busy (clr_busy),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tcs_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	tcs_back #(
		.LINE_WIDTH   (LINE_WIDTH),
		.BUFFER_ROWS  (BUFFER_ROWS),
		.VISIBLE_ROWS (VISIBLE_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.q_stat    (q_stat),
		.cfg_color ({bg_q, fg_q}),
		.pop       (pop),
		.clr_busy  (clr_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	`TCS_ASSERT_IMPL(a_no_accept_in_clear, clr_busy, !s_tready, "transfer accepted during store clear")
	`TCS_ASSERT_IMPL(a_queue_no_overflow, push, !q_stat.full, "command queue overflow")
	`TCS_ASSERT_IMPL(a_cleared_homes, m_tvalid && m_tdata[36], m_tdata[19:0] == 20'h0, "clear did not home cursor and view")
	`TCS_ASSERT_NEXT(a_accept_queued, s_tvalid && s_tready, !q_stat.empty, "accepted command missing from queue")

endmodule
